// ===== rtl/rle_byte_pair_encoder_macros.svh =====
// Assertion macros for the byte-pair run-length encoder.
// No dependencies; include inside a module after its declarations.
`ifndef RLE_BYTE_PAIR_ENCODER_MACROS_SVH
`define RLE_BYTE_PAIR_ENCODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLE_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rle_pkg.sv =====
// Shared types and constants for the byte-pair run-length encoder.
// No dependencies.
`default_nettype none

package rle_pkg;

  localparam int RLE_MAX_RUN = 256;
  localparam int RLE_Q_DEPTH = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_block;
  } rle_in_t;

  typedef struct packed {
    logic [7:0] run_count_minus_one;
    logic [7:0] run_byte;
    logic       last_pair;
  } rle_out_t;

  typedef struct packed {
    logic [1:0] n;
    rle_out_t   pair0;
    rle_out_t   pair1;
  } rle_push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       room;
  } rle_qstat_t;

endpackage

`default_nettype wire

// ===== rtl/rle_pair_queue.sv =====
// Three-entry shift queue holding encoded pairs for the result channel.
// Depends on rle_pkg.
`default_nettype none

module rle_pair_queue
  import rle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  rle_push_t       push,
  output rle_qstat_t      stat,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rle_out_t        out_data
);

  rle_out_t   ent_r   [RLE_Q_DEPTH];
  rle_out_t   ent_nxt [RLE_Q_DEPTH];
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       pop;
  logic [1:0] base;

  assign pop  = (count_r != 2'd0) && !out_stall;
  assign base = count_r - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < RLE_Q_DEPTH; i++) begin
      if (pop && (i < RLE_Q_DEPTH - 1)) begin
        ent_nxt[i] = ent_r[(i + 1) % RLE_Q_DEPTH];
      end else begin
        ent_nxt[i] = ent_r[i];
      end
      if ((push.n != 2'd0) && (2'(i) == base)) begin
        ent_nxt[i] = push.pair0;
      end
      if ((push.n == 2'd2) && (2'(i) == base + 2'd1)) begin
        ent_nxt[i] = push.pair1;
      end
    end
    count_nxt = base + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RLE_Q_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign out_valid  = (count_r != 2'd0);
  assign out_data   = ent_r[0];
  assign stat.count = count_r;
  assign stat.room  = !count_r[1];

endmodule

`default_nettype wire

// ===== rtl/rle_byte_pair_encoder.sv =====
// Byte-pair run-length encoder: pairs from an input transfer are registered into the pair queue.
// Throughput one byte per cycle while the queue has room; a byte yielding two pairs stalls the input.
// Run state updates in the transfer cycle; pairs drain through a three-entry queue.
// Synchronous active-low reset closes the open run and empties the queue.
// Depends on rle_pkg, rle_pair_queue and rle_byte_pair_encoder_macros.svh.
`default_nettype none

module rle_byte_pair_encoder
  import rle_pkg::*;
#(
  parameter int MAX_RUN = RLE_MAX_RUN
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  rle_in_t   in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output rle_out_t  out_data
);

  `include "rle_byte_pair_encoder_macros.svh"

  localparam int LEN_W = $clog2(MAX_RUN + 1);

  logic [7:0]       cur_r,  cur_nxt;
  logic [LEN_W-1:0] len_r,  len_nxt;
  logic             open_r, open_nxt;
  logic             in_xfer;
  logic             close_run;
  logic [LEN_W-1:0] flush_len;
  rle_push_t        push;
  rle_qstat_t       qstat;
  rle_out_t         closed_pair;
  rle_out_t         last_pair_d;

  assign in_stall = !rst_n || !qstat.room;
  assign in_xfer  = in_valid && !in_stall;

  assign close_run = open_r &&
                     ((in_data.data_byte != cur_r) || (len_r >= LEN_W'(MAX_RUN)));

  always_comb begin
    cur_nxt  = cur_r;
    len_nxt  = len_r;
    open_nxt = open_r;
    if (!open_r || close_run) begin
      cur_nxt  = in_data.data_byte;
      len_nxt  = LEN_W'(1);
      open_nxt = 1'b1;
    end else begin
      len_nxt = len_r + LEN_W'(1);
    end
    flush_len = len_nxt;
    if (in_data.last_in_block) begin
      open_nxt = 1'b0;
      len_nxt  = '0;
    end
  end

  always_comb begin
    closed_pair.run_count_minus_one = 8'(len_r - LEN_W'(1));
    closed_pair.run_byte            = cur_r;
    closed_pair.last_pair           = 1'b0;
    last_pair_d.run_count_minus_one = 8'(flush_len - LEN_W'(1));
    last_pair_d.run_byte            = cur_nxt;
    last_pair_d.last_pair           = 1'b1;
    push.n     = '0;
    push.pair0 = closed_pair;
    push.pair1 = last_pair_d;
    if (in_xfer) begin
      push.n = {1'b0, close_run} + {1'b0, in_data.last_in_block};
      if (!close_run) begin
        push.pair0 = last_pair_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      len_r  <= '0;
      open_r <= 1'b0;
    end else if (in_xfer) begin
      cur_r  <= cur_nxt;
      len_r  <= len_nxt;
      open_r <= open_nxt;
    end
  end

  rle_pair_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (qstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `RLE_ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, (len_r <= LEN_W'(MAX_RUN)), "run too long")
  `RLE_ASSERT_IMPL(a_closed_empty, clk, rst_n, !open_r, (len_r == '0), "closed run holds bytes")
  `RLE_ASSERT_NEXT(a_last_closes, clk, rst_n, in_xfer && in_data.last_in_block,
                   !open_r, "run open after last byte")
  `RLE_ASSERT_IMPL(a_full_stalls, clk, rst_n, (qstat.count == 2'd3),
                   in_stall, "input open with full queue")

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for rle_byte_pair_encoder: predicts run/value pairs per transfer
// and compares them with the pairs the block sends out.
// Depends on rle_pkg and the rle_byte_pair_encoder RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rle_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 8;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rle_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rle_out_t out_data;

  rle_out_t   pending_pairs[$];
  logic [7:0] run_val;
  logic [8:0] run_len;
  logic       run_active;

  bit tx_gaps_on;
  bit rx_gaps_on;
  bit hold_off_req;
  int error_count;
  int bytes_sent;
  int pairs_checked;
  int full_runs;
  int input_held_cycles;
  int quiet_cycles;

  rle_byte_pair_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rle_out_t make_pair(input logic is_last);
    rle_out_t p;
    p.run_count_minus_one = 8'(run_len - 9'd1);
    p.run_byte            = run_val;
    p.last_pair           = is_last;
    return p;
  endfunction

  task automatic encode_byte(input rle_in_t item);
    if (!run_active) begin
      run_val    = item.data_byte;
      run_len    = 9'd1;
      run_active = 1'b1;
    end else if (item.data_byte != run_val || run_len >= 9'(RLE_MAX_RUN)) begin
      pending_pairs.push_back(make_pair(1'b0));
      run_val = item.data_byte;
      run_len = 9'd1;
    end else begin
      run_len = run_len + 9'd1;
    end
    if (item.last_in_block) begin
      pending_pairs.push_back(make_pair(1'b1));
      run_active = 1'b0;
      run_len    = 9'd0;
    end
  endtask

  task automatic report_pair(input string what, input rle_out_t want, input rle_out_t got);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected %0d/%02h/%0b, got %0d/%02h/%0b (count-1/byte/last)",
               $realtime, what, want.run_count_minus_one, want.run_byte, want.last_pair,
               got.run_count_minus_one, got.run_byte, got.last_pair);
  endtask

  // predict on input transfers, check output transfers, watch for a hang
  always @(posedge clk) begin
    rle_out_t want;
    if (rst_n) begin
      if (in_valid && in_stall)
        input_held_cycles++;
      if (in_valid && !in_stall)
        encode_byte(in_data);
      if (out_valid && !out_stall) begin
        pairs_checked++;
        if (out_data.run_count_minus_one == 8'hFF)
          full_runs++;
        if (pending_pairs.size() == 0) begin
          report_pair("unexpected pair", '0, out_data);
        end else begin
          want = pending_pairs.pop_front();
          if (out_data.run_count_minus_one !== want.run_count_minus_one ||
              out_data.run_byte !== want.run_byte ||
              out_data.last_pair !== want.last_pair)
            report_pair("pair mismatch", want, out_data);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no transfer for %0d cycles, %0d pairs outstanding",
                 $realtime, quiet_cycles, pending_pairs.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (stall_left == 0 && rx_gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    rle_in_t item;
    item.data_byte     = b;
    item.last_in_block = is_last;
    if (tx_gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic [7:0] b, input int n, input logic close_block);
    for (int i = 0; i < n; i++)
      send_byte(b, close_block && (i == n - 1));
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic test_short_blocks;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_run(8'hFF, 3, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_run(8'h0F, 2, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_run(8'h5A, 2, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_drained();
  endtask

  task automatic test_run_full;
    send_run(8'h3C, 256, 1'b1);
    send_run(8'h00, 257, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_hold_off;
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom_range(0, 255)), (i % 8) == 7);
    wait_drained();
    for (int i = 0; i < 12; i++)
      send_byte(8'(i * 17), i == 11);
    wait_drained();
  endtask

  task automatic test_random_blocks(input int n_items);
    int         sent;
    int         left;
    int         run;
    logic [7:0] val;
    sent = 0;
    val  = 8'h00;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        sent++;
      end else begin
        left = ($urandom_range(0, 99) == 0) ? $urandom_range(200, 520) : $urandom_range(1, 24);
        if (left > n_items - sent)
          left = n_items - sent;
        while (left > 0) begin
          if (left >= 200)
            run = left;
          else
            run = $urandom_range(1, (left < 5) ? left : 5);
          if ($urandom_range(0, 3) != 0)
            val = 8'($urandom_range(0, 255));
          send_run(val, run, left == run);
          left -= run;
          sent += run;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    run_val      = 8'h00;
    run_len      = 9'd0;
    run_active   = 1'b0;
    tx_gaps_on   = 1'b0;
    rx_gaps_on   = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_blocks();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_run_full();
    test_output_hold_off();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_random_blocks(200);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    test_random_blocks(70);

    if (pending_pairs.size() != 0) begin
      $display("%0d expected pairs never arrived", pending_pairs.size());
      error_count += pending_pairs.size();
    end
    $display("summary: %0d bytes sent, %0d pairs checked, %0d of them full 256-byte runs",
             bytes_sent, pairs_checked, full_runs);
    $display("summary: input held off for %0d cycles, %0d mismatches",
             input_held_cycles, error_count);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== rle_byte_pair_encoder.f =====
+incdir+rtl
rtl/rle_pkg.sv
rtl/rle_pair_queue.sv
rtl/rle_byte_pair_encoder.sv
bench/testbench.sv
